>>> hw/rtl/positional_list_engine_unit_assert.svh
// Assertion helpers for the positional list engine.
// Both expect clk and arst_n in scope.
`ifndef POSITIONAL_LIST_ENGINE_UNIT_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define PLEN_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("plen assertion failed");

// Next-cycle implication.
`define PLEN_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("plen assertion failed");

`endif

>>> hw/rtl/plen_pkg.sv
package plen_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	localparam int CMD_W    = 2;
	localparam int POS_W    = 5;
	localparam int WORD_W   = 32;
	localparam int STAT_W   = 2;
	localparam int COUNT_W  = 5;

	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DUMP   = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
	localparam logic [STAT_W-1:0] ST_BADPOS = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;

	// per-cycle cell operation, broadcast along the chain
	localparam logic [1:0] CELL_HOLD = 2'd0;
	localparam logic [1:0] CELL_INS  = 2'd1;
	localparam logic [1:0] CELL_DEL  = 2'd2;
	localparam logic [1:0] CELL_ROT  = 2'd3;

	typedef logic signed [WORD_W-1:0] plen_word_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [POS_W-1:0] position;
		plen_word_t       value;
	} plen_req_t;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [COUNT_W-1:0] entry_count;
		plen_word_t         entry_value;
		logic               has_value;
		logic               last;
	} plen_rsp_t;

	typedef struct packed {
		logic [1:0]       op;
		logic [IDX_W-1:0] pos_idx;   // target slot for insert / delete
		logic [IDX_W-1:0] last_idx;  // highest held slot, for rotation
	} plen_cell_ctrl_t;

endpackage

>>> hw/rtl/plen_cell.sv
module plen_cell import plen_pkg::*; (
	input  logic            clk,
	input  logic [IDX_W-1:0] idx,
	input  plen_cell_ctrl_t ctrl,
	input  plen_word_t      new_val,
	input  plen_word_t      left_val,
	input  plen_word_t      right_val,
	input  plen_word_t      wrap_val,
	output plen_word_t      val
);

	plen_word_t val_q;
	plen_word_t val_d;

	always_comb begin
		val_d = val_q;
		unique case (ctrl.op)
			CELL_INS: begin
				if (idx > ctrl.pos_idx) val_d = left_val;
				else if (idx == ctrl.pos_idx) val_d = new_val;
			end
			CELL_DEL: begin
				if (idx >= ctrl.pos_idx) val_d = right_val;
			end
			CELL_ROT: begin
				// ring over held slots: slot 0 wraps to the top held slot
				if (idx < ctrl.last_idx) val_d = right_val;
				else if (idx == ctrl.last_idx) val_d = wrap_val;
			end
			default: val_d = val_q;
		endcase
	end

	always_ff @(posedge clk) begin
		val_q <= val_d;
	end

	assign val = val_q;

endmodule

>>> hw/rtl/positional_list_engine_unit.sv
// Positional list engine: an ordered list of up to CAPACITY signed words held
// in a chain of cells. A command beat is taken when start is high and busy is
// low. Insert, delete, a bad command and a dump of an empty list give one result
// beat on the cycle after acceptance; busy stays low, so a new command may follow
// at once. A dump of N held entries gives N result beats, one per cycle, through
// the dump state and then the result register; busy is high during the dump. The
// chain rotates one place a cycle, setting the dump rate: slot 0 is read out and
// wraps to the top held slot, so after N places the list is back in order. Each
// result beat is on rsp for exactly one cycle, marked by rsp_valid; the receiver
// cannot stall, so it must take every beat as shown.
`include "positional_list_engine_unit_assert.svh"

module positional_list_engine_unit import plen_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  plen_req_t req,
	output logic      rsp_valid,
	output plen_rsp_t rsp
);

	localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_DUMP = 1'b1;

	logic             state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [IDX_W-1:0] dump_idx_q, dump_idx_d;
	logic             rsp_valid_q, rsp_valid_d;
	plen_rsp_t        rsp_q, rsp_d;

	plen_cell_ctrl_t  ctrl;
	plen_word_t       cell_val [CAPACITY];

	logic             accept;
	logic [CMP_W-1:0] pos_x, cnt_x;
	logic             ins_pos_ok, del_pos_ok, full;
	logic [IDX_W-1:0] last_idx;

	assign busy   = (state_q == ST_DUMP);
	assign accept = start && !busy;

	assign pos_x      = CMP_W'(req.position);
	assign cnt_x      = CMP_W'(count_q);
	assign ins_pos_ok = (pos_x != '0) && (pos_x <= cnt_x + CMP_W'(1));
	assign del_pos_ok = (pos_x != '0) && (pos_x <= cnt_x);
	assign full       = (cnt_x == CMP_W'(CAPACITY));
	assign last_idx   = IDX_W'(count_q - CNT_W'(1));

	// command decode and dump sequencing
	always_comb begin
		state_d       = state_q;
		count_d       = count_q;
		dump_idx_d    = dump_idx_q;
		rsp_valid_d   = 1'b0;
		rsp_d         = rsp_q;
		ctrl.op       = CELL_HOLD;
		ctrl.pos_idx  = IDX_W'(req.position - POS_W'(1));
		ctrl.last_idx = last_idx;

		if (busy) begin
			// one entry per cycle from the head of the ring
			ctrl.op           = CELL_ROT;
			rsp_valid_d       = 1'b1;
			rsp_d.status      = ST_OK;
			rsp_d.entry_count = COUNT_W'(count_q);
			rsp_d.entry_value = cell_val[0];
			rsp_d.has_value   = 1'b1;
			rsp_d.last        = (dump_idx_q == last_idx);
			dump_idx_d        = dump_idx_q + IDX_W'(1);
			if (dump_idx_q == last_idx) state_d = ST_IDLE;
		end else if (accept) begin
			rsp_valid_d       = 1'b1;
			rsp_d.status      = ST_BADPOS;
			rsp_d.entry_value = '0;
			rsp_d.has_value   = 1'b0;
			rsp_d.last        = 1'b1;
			unique case (req.cmd)
				CMD_INSERT: begin
					// position check first, then the full check
					if (!ins_pos_ok) begin
						rsp_d.status = ST_BADPOS;
					end else if (full) begin
						rsp_d.status = ST_FULL;
					end else begin
						ctrl.op      = CELL_INS;
						count_d      = count_q + CNT_W'(1);
						rsp_d.status = ST_OK;
					end
				end
				CMD_DELETE: begin
					if (del_pos_ok) begin
						ctrl.op      = CELL_DEL;
						count_d      = count_q - CNT_W'(1);
						rsp_d.status = ST_OK;
					end
				end
				CMD_DUMP: begin
					rsp_d.status = ST_OK;
					if (count_q != '0) begin
						// results come from the dump state
						rsp_valid_d = 1'b0;
						state_d     = ST_DUMP;
						dump_idx_d  = '0;
					end
				end
				default: rsp_d.status = ST_BADPOS;
			endcase
			rsp_d.entry_count = COUNT_W'(count_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			dump_idx_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			dump_idx_q  <= dump_idx_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		rsp_q <= rsp_d;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// cell chain: left neighbor feeds inserts, right neighbor feeds deletes
	// and rotation, slot 0 wraps to the top during a dump
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		plen_word_t left_v, right_v;
		if (i == 0) begin : g_head
			assign left_v = req.value;
		end else begin : g_body
			assign left_v = cell_val[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign right_v = cell_val[i];
		end else begin : g_mid
			assign right_v = cell_val[i+1];
		end
		plen_cell u_cell (
			.clk       (clk),
			.idx       (IDX_W'(i)),
			.ctrl      (ctrl),
			.new_val   (req.value),
			.left_val  (left_v),
			.right_val (right_v),
			.wrap_val  (cell_val[0]),
			.val       (cell_val[i])
		);
	end

	`PLEN_ASSERT_NOW(a_count_bound, 1'b1, cnt_x <= CMP_W'(CAPACITY))
	`PLEN_ASSERT_NEXT(a_dump_beat, busy, rsp_valid)
	`PLEN_ASSERT_NOW(a_mid_dump_busy, rsp_valid && !rsp.last, busy)
	`PLEN_ASSERT_NOW(a_value_ok, rsp_valid && rsp.has_value, rsp.status == ST_OK)

endmodule
